[hdl/catapult_launch_sequencer_unit_defines.svh]
// Assertion shorthands for the launch sequencer checks.
// All checks sample on clk_i and stay quiet while rst_ni is low.
`ifndef CATAPULT_LAUNCH_SEQUENCER_UNIT_DEFINES_SVH
`define CATAPULT_LAUNCH_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cls_pkg.sv]
package cls_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int ACC_W      = 20;
  localparam int THR_W      = 19;
  localparam int TICK_W     = 16;
  localparam int THROTTLE_W = 14;
  localparam int DIST_W     = 16;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Climb point arithmetic
  localparam int FRAC_SHIFT = 8;                    // metres to Q24.8
  localparam int QUO_W      = DIST_W + FRAC_SHIFT + 1;
  localparam int SQ_W       = 64;                   // sum of squares, remainders
  localparam int ROOT_W     = 32;
  localparam int MUL_W      = 32;
  localparam int CNT_W      = 6;
  localparam logic [SQ_W-1:0] ROOT_START = 64'h4000_0000_0000_0000;

  // Op codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_NAV  = 2'd1;
  localparam logic [OP_W-1:0] OP_ARM  = 2'd2;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_HOLD    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_POWER   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CAPTURE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_CLIMB   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_DELAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_THROTTLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB_DISTANCE  = 3'd4;

  localparam logic [TICK_W-1:0] LOCKED_TICKS = 16'hffff;

  typedef struct packed {
    logic [THR_W-1:0]      accel_threshold;
    logic [TICK_W-1:0]     motor_delay_ticks;
    logic [TICK_W-1:0]     heading_delay_ticks;
    logic [THROTTLE_W-1:0] full_throttle;
    logic [DIST_W-1:0]     climb_distance;
  } cls_cfg_t;

  localparam cls_cfg_t CFG_RESET = '{
    accel_threshold:     19'd15068,
    motor_delay_ticks:   16'd45,
    heading_delay_ticks: 16'd180,
    full_throttle:       14'd9600,
    climb_distance:      16'd300
  };

  typedef struct packed {
    logic done;
    logic zero;
  } cls_climb_stat_t;

endpackage

[hdl/cls_cfg_regs.sv]
module cls_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [cls_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cls_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output cls_pkg::cls_cfg_t                cfg_o
);

  cls_pkg::cls_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cls_pkg::REG_ACCEL_THRESHOLD:
          cfg_d.accel_threshold = cfg_data_i[cls_pkg::THR_W-1:0];
        cls_pkg::REG_MOTOR_DELAY:
          cfg_d.motor_delay_ticks = cfg_data_i[cls_pkg::TICK_W-1:0];
        cls_pkg::REG_HEADING_DELAY:
          cfg_d.heading_delay_ticks = cfg_data_i[cls_pkg::TICK_W-1:0];
        cls_pkg::REG_FULL_THROTTLE:
          cfg_d.full_throttle = cfg_data_i[cls_pkg::THROTTLE_W-1:0];
        cls_pkg::REG_CLIMB_DISTANCE:
          cfg_d.climb_distance = cfg_data_i[cls_pkg::DIST_W-1:0];
        default: cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cls_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/cls_climb.sv]
module cls_climb #(
  parameter int POS_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [POS_WIDTH-1:0]         pos_east_i,
  input  logic signed [POS_WIDTH-1:0]         pos_north_i,
  input  logic signed [POS_WIDTH-1:0]         base_east_i,
  input  logic signed [POS_WIDTH-1:0]         base_north_i,
  input  logic [cls_pkg::DIST_W-1:0]          climb_distance_i,
  output cls_pkg::cls_climb_stat_t            stat_o,
  output logic signed [POS_WIDTH-1:0]         climb_east_o,
  output logic signed [POS_WIDTH-1:0]         climb_north_o
);

  localparam int DW = POS_WIDTH + 1;
  localparam int NW = (DW > cls_pkg::MUL_W) ? DW : cls_pkg::MUL_W;
  localparam int SW = ((POS_WIDTH > cls_pkg::QUO_W) ? POS_WIDTH : cls_pkg::QUO_W) + 2;
  localparam logic signed [SW-1:0] POS_MAX =
    SW'((longint'(1) <<< (POS_WIDTH - 1)) - longint'(1));
  localparam logic signed [SW-1:0] POS_MIN = SW'(-(longint'(1) <<< (POS_WIDTH - 1)));

  typedef enum logic [8:0] {
    C_IDLE  = 9'b000000001,
    C_NORM  = 9'b000000010,
    C_SQX   = 9'b000000100,
    C_SQY   = 9'b000001000,
    C_ROOT  = 9'b000010000,
    C_MUL   = 9'b000100000,
    C_DIV   = 9'b001000000,
    C_APPLY = 9'b010000000,
    C_DONE  = 9'b100000000
  } climb_state_e;

  climb_state_e state_d, state_q;

  logic [NW-1:0]                   mx_d, mx_q, my_d, my_q;
  logic                            neg_e_d, neg_e_q, neg_n_d, neg_n_q;
  logic signed [POS_WIDTH-1:0]     base_e_d, base_e_q, base_n_d, base_n_q;
  logic [cls_pkg::SQ_W-1:0]        acc_d, acc_q;   // sum of squares, then dividend
  logic [cls_pkg::SQ_W-1:0]        res_d, res_q;   // root being built
  logic [cls_pkg::SQ_W-1:0]        aux_d, aux_q;   // root bit, then shifted divisor
  logic [cls_pkg::QUO_W-1:0]       quo_d, quo_q;
  logic [cls_pkg::CNT_W-1:0]       cnt_d, cnt_q;
  logic                            axis_d, axis_q; // 0 east, 1 north
  logic                            zero_d, zero_q;
  logic signed [POS_WIDTH-1:0]     ce_d, ce_q, cn_d, cn_q;

  // Differences from takeoff as magnitude and sign
  logic signed [DW-1:0] dx_e, dx_n;
  logic [DW-1:0]        mag_e, mag_n;
  assign dx_e  = DW'(pos_east_i) - DW'(base_east_i);
  assign dx_n  = DW'(pos_north_i) - DW'(base_north_i);
  assign mag_e = dx_e[DW-1] ? DW'(-dx_e) : dx_e;
  assign mag_n = dx_n[DW-1] ? DW'(-dx_n) : dx_n;

  logic [NW-1:0] norm_m;
  logic          norm_hi, norm_lo;
  assign norm_m  = mx_q | my_q;
  assign norm_hi = |norm_m[NW-1:31];
  assign norm_lo = |norm_m[NW-1:30];

  // Shared multiplier
  logic [cls_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [cls_pkg::SQ_W-1:0]  prod;
  assign prod = cls_pkg::SQ_W'(mul_a) * cls_pkg::SQ_W'(mul_b);

  // Shared compare-and-subtract for root and division
  logic [cls_pkg::SQ_W-1:0] sub_b;
  logic [cls_pkg::SQ_W:0]   diff;
  logic                     fits;
  assign sub_b = (state_q == C_ROOT) ? (res_q + aux_q) : aux_q;
  assign diff  = {1'b0, acc_q} - {1'b0, sub_b};
  assign fits  = !diff[cls_pkg::SQ_W];

  logic [cls_pkg::ROOT_W-1:0] l_root;
  assign l_root = res_q[cls_pkg::ROOT_W-1:0];

  // Offset apply with saturation
  logic signed [POS_WIDTH-1:0] base_sel;
  logic                        neg_sel;
  logic signed [SW-1:0]        base_s, off_s, sum_s;
  logic signed [POS_WIDTH-1:0] sat;
  assign base_sel = axis_q ? base_n_q : base_e_q;
  assign neg_sel  = axis_q ? neg_n_q : neg_e_q;
  assign base_s   = SW'(base_sel);
  assign off_s    = $signed(SW'(quo_q));
  assign sum_s    = neg_sel ? (base_s - off_s) : (base_s + off_s);
  assign sat      = (sum_s > POS_MAX) ? POS_MAX[POS_WIDTH-1:0] :
                    (sum_s < POS_MIN) ? POS_MIN[POS_WIDTH-1:0] : sum_s[POS_WIDTH-1:0];

  always_comb begin
    state_d  = state_q;
    mx_d     = mx_q;
    my_d     = my_q;
    neg_e_d  = neg_e_q;
    neg_n_d  = neg_n_q;
    base_e_d = base_e_q;
    base_n_d = base_n_q;
    acc_d    = acc_q;
    res_d    = res_q;
    aux_d    = aux_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    axis_d   = axis_q;
    zero_d   = zero_q;
    ce_d     = ce_q;
    cn_d     = cn_q;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          mx_d     = NW'(mag_e);
          my_d     = NW'(mag_n);
          neg_e_d  = dx_e[DW-1];
          neg_n_d  = dx_n[DW-1];
          base_e_d = base_east_i;
          base_n_d = base_north_i;
          zero_d   = 1'b0;
          state_d  = C_NORM;
        end
      end
      C_NORM: begin
        // Bring the larger magnitude into [2^30, 2^31), one bit a cycle
        if (norm_m == '0) begin
          zero_d  = 1'b1;
          ce_d    = base_e_q;
          cn_d    = base_n_q;
          state_d = C_DONE;
        end else if (norm_hi) begin
          mx_d = mx_q >> 1;
          my_d = my_q >> 1;
        end else if (!norm_lo) begin
          mx_d = mx_q << 1;
          my_d = my_q << 1;
        end else begin
          state_d = C_SQX;
        end
      end
      C_SQX: begin
        mul_a   = mx_q[cls_pkg::MUL_W-1:0];
        mul_b   = mx_q[cls_pkg::MUL_W-1:0];
        acc_d   = prod;
        state_d = C_SQY;
      end
      C_SQY: begin
        mul_a   = my_q[cls_pkg::MUL_W-1:0];
        mul_b   = my_q[cls_pkg::MUL_W-1:0];
        acc_d   = acc_q + prod;
        res_d   = '0;
        aux_d   = cls_pkg::ROOT_START;
        cnt_d   = cls_pkg::CNT_W'(cls_pkg::ROOT_W - 1);
        state_d = C_ROOT;
      end
      C_ROOT: begin
        if (fits) begin
          acc_d = diff[cls_pkg::SQ_W-1:0];
          res_d = (res_q >> 1) + aux_q;
        end else begin
          res_d = res_q >> 1;
        end
        aux_d = aux_q >> 2;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          axis_d  = 1'b0;
          state_d = C_MUL;
        end
      end
      C_MUL: begin
        // Dividend a*dist*256 + L/2, divisor L aligned to the top quotient bit
        mul_a   = axis_q ? my_q[cls_pkg::MUL_W-1:0] : mx_q[cls_pkg::MUL_W-1:0];
        mul_b   = cls_pkg::MUL_W'(climb_distance_i);
        acc_d   = (prod << cls_pkg::FRAC_SHIFT) + (cls_pkg::SQ_W'(l_root) >> 1);
        aux_d   = cls_pkg::SQ_W'(l_root) << (cls_pkg::QUO_W - 1);
        quo_d   = '0;
        cnt_d   = cls_pkg::CNT_W'(cls_pkg::QUO_W - 1);
        state_d = C_DIV;
      end
      C_DIV: begin
        if (fits) begin
          acc_d = diff[cls_pkg::SQ_W-1:0];
        end
        quo_d = {quo_q[cls_pkg::QUO_W-2:0], fits};
        aux_d = aux_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = C_APPLY;
        end
      end
      C_APPLY: begin
        if (axis_q) begin
          cn_d    = sat;
          state_d = C_DONE;
        end else begin
          ce_d    = sat;
          axis_d  = 1'b1;
          state_d = C_MUL;
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q     <= mx_d;
    my_q     <= my_d;
    neg_e_q  <= neg_e_d;
    neg_n_q  <= neg_n_d;
    base_e_q <= base_e_d;
    base_n_q <= base_n_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    aux_q    <= aux_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    axis_q   <= axis_d;
    zero_q   <= zero_d;
    ce_q     <= ce_d;
    cn_q     <= cn_d;
  end

  assign stat_o.done   = (state_q == C_DONE);
  assign stat_o.zero   = zero_q;
  assign climb_east_o  = ce_q;
  assign climb_north_o = cn_q;

endmodule

[hdl/catapult_launch_sequencer_unit.sv]
// Catapult launch sequencer. Takes one op per beat (tick, nav step, arm) and
// returns exactly one result beat for it. Ticks, arms, unused ops and nav
// steps outside heading capture go from accept through latch, evaluate and a
// push into the output register, the push waiting while that register is full.
// The heading-capture nav step runs the climb point unit, which reuses one
// multiplier and one 64-bit compare/subtract: normalize one bit per cycle
// (0 to 30 shifts at the default position width), two squares, a 32-step
// square root, then per axis one multiply, a 25-step division and a
// saturating add. A capture with no movement since takeoff goes from the
// normalize step straight to done. The block holds one item at a time:
// in_ready_o is high only while idle, but the output register lets a new
// beat in while the previous result still waits for out_ready_i.
// Configuration writes are registered directly (cfg_ready_o is always high)
// and are meant to be issued only while the block is idle.
module catapult_launch_sequencer_unit #(
  parameter int POS_WIDTH    = 32,
  parameter int DETECT_COUNT = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Input beats
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [cls_pkg::OP_W-1:0]                op_i,
  input  logic signed [cls_pkg::ACC_W-1:0]        accel_fwd_i,
  input  logic signed [POS_WIDTH-1:0]             pos_east_i,
  input  logic signed [POS_WIDTH-1:0]             pos_north_i,
  // Configuration writes
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [cls_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [cls_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  // Result beats
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [cls_pkg::PHASE_W-1:0]             phase_o,
  output logic [cls_pkg::THROTTLE_W-1:0]          throttle_cmd_o,
  output logic                                    motor_start_o,
  output logic signed [POS_WIDTH-1:0]             climb_east_o,
  output logic signed [POS_WIDTH-1:0]             climb_north_o,
  output logic                                    point_new_o,
  output logic                                    zero_distance_o,
  output logic signed [POS_WIDTH-1:0]             takeoff_east_o,
  output logic signed [POS_WIDTH-1:0]             takeoff_north_o
);

  localparam logic [cls_pkg::TICK_W-1:0] DETECT_TICKS = cls_pkg::TICK_W'(DETECT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CLIMB = 4'b0100,
    S_PUSH  = 4'b1000
  } seq_state_e;

  // Phase from the tick counter
  function automatic logic [cls_pkg::PHASE_W-1:0] phase_of(
    input logic [cls_pkg::TICK_W-1:0] c,
    input logic [cls_pkg::TICK_W-1:0] motor_delay,
    input logic [cls_pkg::TICK_W-1:0] heading_delay
  );
    logic [cls_pkg::PHASE_W-1:0] ph;
    if (c <= motor_delay) begin
      ph = cls_pkg::PH_HOLD;
    end else if (c < heading_delay) begin
      ph = cls_pkg::PH_POWER;
    end else if (c == cls_pkg::LOCKED_TICKS) begin
      ph = cls_pkg::PH_CLIMB;
    end else begin
      ph = cls_pkg::PH_CAPTURE;
    end
    return ph;
  endfunction

  cls_pkg::cls_cfg_t        cfg;
  cls_pkg::cls_climb_stat_t climb_stat;
  logic signed [POS_WIDTH-1:0] climb_e, climb_n;

  seq_state_e state_d, state_q;

  // Held input beat
  logic [cls_pkg::OP_W-1:0]          op_q;
  logic signed [cls_pkg::ACC_W-1:0]  accel_q;
  logic signed [POS_WIDTH-1:0]       pe_q, pn_q;

  // Launch state
  logic                            armed_d, armed_q;
  logic [cls_pkg::TICK_W-1:0]      ticks_d, ticks_q;
  logic signed [POS_WIDTH-1:0]     start_e_d, start_e_q, start_n_d, start_n_q;

  // Pending result, before the output register
  logic [cls_pkg::PHASE_W-1:0]     res_phase_d, res_phase_q;
  logic [cls_pkg::THROTTLE_W-1:0]  res_thr_d, res_thr_q;
  logic                            res_motor_d, res_motor_q;
  logic                            res_pnew_d, res_pnew_q;

  // Output register
  logic                            out_valid_d, out_valid_q;
  logic                            out_load, out_free;
  logic [cls_pkg::PHASE_W-1:0]     out_phase_q;
  logic [cls_pkg::THROTTLE_W-1:0]  out_thr_q;
  logic                            out_motor_q, out_pnew_q, out_zero_q;
  logic signed [POS_WIDTH-1:0]     out_ce_q, out_cn_q, out_te_q, out_tn_q;

  logic                            in_accept, climb_start;

  // Tick path
  logic [cls_pkg::TICK_W-1:0]      tick_ticks;
  logic                            tick_motor, acc_low;
  logic [cls_pkg::PHASE_W-1:0]     ph_cur, ph_tick, ph_arm;

  cls_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cls_climb #(
    .POS_WIDTH (POS_WIDTH)
  ) u_climb (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (climb_start),
    .pos_east_i       (pe_q),
    .pos_north_i      (pn_q),
    .base_east_i      (start_e_q),
    .base_north_i     (start_n_q),
    .climb_distance_i (cfg.climb_distance),
    .stat_o           (climb_stat),
    .climb_east_o     (climb_e),
    .climb_north_o    (climb_n)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;

  // Below-threshold sample: signed accel against the unsigned threshold
  assign acc_low = accel_q < $signed({1'b0, cfg.accel_threshold});

  always_comb begin
    tick_motor = 1'b0;
    if (armed_q) begin
      // Advance up to the heading delay, restart on a weak sample early on
      tick_ticks = (ticks_q < cfg.heading_delay_ticks) ? (ticks_q + 1'b1) : ticks_q;
      if (tick_ticks < DETECT_TICKS) begin
        if (acc_low) begin
          tick_ticks = '0;
        end
      end else if (tick_ticks >= cfg.motor_delay_ticks) begin
        tick_motor = 1'b1;
      end
    end else begin
      tick_ticks = '0;
    end
  end

  assign ph_cur  = phase_of(ticks_q, cfg.motor_delay_ticks, cfg.heading_delay_ticks);
  assign ph_tick = phase_of(tick_ticks, cfg.motor_delay_ticks, cfg.heading_delay_ticks);
  assign ph_arm  = phase_of('0, cfg.motor_delay_ticks, cfg.heading_delay_ticks);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    ticks_d     = ticks_q;
    start_e_d   = start_e_q;
    start_n_d   = start_n_q;
    res_phase_d = res_phase_q;
    res_thr_d   = res_thr_q;
    res_motor_d = res_motor_q;
    res_pnew_d  = res_pnew_q;
    climb_start = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_thr_d   = '0;
        res_motor_d = 1'b0;
        res_pnew_d  = 1'b0;
        unique case (op_q)
          cls_pkg::OP_TICK: begin
            ticks_d     = tick_ticks;
            res_phase_d = ph_tick;
            res_motor_d = tick_motor;
            res_thr_d   = tick_motor ? cfg.full_throttle : '0;
          end
          cls_pkg::OP_NAV: begin
            armed_d     = 1'b1;
            res_phase_d = ph_cur;
            unique case (ph_cur)
              cls_pkg::PH_HOLD: begin
                // Still on the catapult: track the takeoff point
                start_e_d = pe_q;
                start_n_d = pn_q;
              end
              cls_pkg::PH_POWER: begin
                res_thr_d = cfg.full_throttle;
              end
              cls_pkg::PH_CAPTURE: begin
                res_thr_d   = cfg.full_throttle;
                res_pnew_d  = 1'b1;
                ticks_d     = cls_pkg::LOCKED_TICKS;
                climb_start = 1'b1;
              end
              cls_pkg::PH_CLIMB: begin
                res_thr_d = '0;  // throttle belongs to the climb loop now
              end
              default: begin
                res_thr_d = '0;
              end
            endcase
          end
          cls_pkg::OP_ARM: begin
            armed_d     = 1'b1;
            ticks_d     = '0;
            res_phase_d = ph_arm;
            res_thr_d   = (ph_arm == cls_pkg::PH_POWER || ph_arm == cls_pkg::PH_CAPTURE) ?
                          cfg.full_throttle : '0;
          end
          default: begin
            // Unused op: report status, change nothing
            res_phase_d = ph_cur;
            res_thr_d   = (ph_cur == cls_pkg::PH_POWER || ph_cur == cls_pkg::PH_CAPTURE) ?
                          cfg.full_throttle : '0;
          end
        endcase
        state_d = climb_start ? S_CLIMB : S_PUSH;
      end
      S_CLIMB: begin
        if (climb_stat.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      ticks_q     <= '0;
      start_e_q   <= '0;
      start_n_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      ticks_q     <= ticks_d;
      start_e_q   <= start_e_d;
      start_n_q   <= start_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      accel_q <= accel_fwd_i;
      pe_q    <= pos_east_i;
      pn_q    <= pos_north_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_phase_q <= res_phase_d;
    res_thr_q   <= res_thr_d;
    res_motor_q <= res_motor_d;
    res_pnew_q  <= res_pnew_d;
  end

  // Output register; climb fields read as zero unless a point was computed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q <= res_phase_q;
      out_thr_q   <= res_thr_q;
      out_motor_q <= res_motor_q;
      out_pnew_q  <= res_pnew_q;
      out_zero_q  <= res_pnew_q && climb_stat.zero;
      out_ce_q    <= res_pnew_q ? climb_e : '0;
      out_cn_q    <= res_pnew_q ? climb_n : '0;
      out_te_q    <= start_e_q;
      out_tn_q    <= start_n_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_o         = out_phase_q;
  assign throttle_cmd_o  = out_thr_q;
  assign motor_start_o   = out_motor_q;
  assign climb_east_o    = out_ce_q;
  assign climb_north_o   = out_cn_q;
  assign point_new_o     = out_pnew_q;
  assign zero_distance_o = out_zero_q;
  assign takeoff_east_o  = out_te_q;
  assign takeoff_north_o = out_tn_q;

endmodule

[hdl/cls_checker.sv]
`include "catapult_launch_sequencer_unit_defines.svh"

module cls_checker #(
  parameter int POS_WIDTH = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [cls_pkg::PHASE_W-1:0]         phase_o,
  input logic [cls_pkg::THROTTLE_W-1:0]      throttle_cmd_o,
  input logic                                motor_start_o,
  input logic signed [POS_WIDTH-1:0]         climb_east_o,
  input logic signed [POS_WIDTH-1:0]         climb_north_o,
  input logic                                point_new_o,
  input logic                                zero_distance_o
);

  // A stalled result stays put
  `CLS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(phase_o) && $stable(throttle_cmd_o) && $stable(climb_east_o), "result changed while stalled")

  // One item in flight: ready drops after every accept
  `CLS_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second beat taken while busy")

  // A climb point only comes out of the heading-capture step
  `CLS_ASSERT_IMP(a_point_phase, out_valid_o && point_new_o, phase_o == cls_pkg::PH_CAPTURE, "climb point outside capture phase")

  // Without a new point the climb fields are cleared
  `CLS_ASSERT_IMP(a_point_clear, out_valid_o && !point_new_o, climb_east_o == '0 && climb_north_o == '0 && !zero_distance_o, "stale climb fields")

  // In climb phase throttle comes only from a tick with the motor running
  `CLS_ASSERT_IMP(a_climb_thr, out_valid_o && phase_o == cls_pkg::PH_CLIMB && !motor_start_o, throttle_cmd_o == '0, "throttle commanded in climb phase")

endmodule

bind catapult_launch_sequencer_unit cls_checker #(.POS_WIDTH(POS_WIDTH)) u_cls_checker (.*);

[test/catapult_launch_sequencer_unit_tb.sv]
`timescale 1ns / 100ps

module catapult_launch_sequencer_unit_tb;

  localparam int POS_W         = 32;
  localparam int DETECT_TICKS  = 5;
  localparam int IDLE_PCT      = 28;
  localparam int RANDOM_BEATS  = 500;
  localparam int ROUND_BEATS   = 45;
  localparam int STALL_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 40;
  localparam int SETTLE_CYCLES = 40;

  // op 3 is not decoded by the block; it only reports status
  localparam logic [cls_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [cls_pkg::ACC_W-1:0] ACC_MAX = 20'sh7ffff;
  localparam logic signed [cls_pkg::ACC_W-1:0] ACC_MIN = 20'sh80000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fffffff;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

  // One status beat as the block reports it
  typedef struct packed {
    logic [cls_pkg::PHASE_W-1:0]    phase;
    logic [cls_pkg::THROTTLE_W-1:0] throttle;
    logic                           motor_start;
    logic [POS_W-1:0]               climb_east;
    logic [POS_W-1:0]               climb_north;
    logic                           point_new;
    logic                           zero_distance;
    logic [POS_W-1:0]               takeoff_east;
    logic [POS_W-1:0]               takeoff_north;
  } launch_status_t;

  // Clock, reset and all block inputs start at known values
  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic [cls_pkg::OP_W-1:0]          op        = cls_pkg::OP_TICK;
  logic signed [cls_pkg::ACC_W-1:0]  accel     = '0;
  logic signed [POS_W-1:0]           pos_east  = '0;
  logic signed [POS_W-1:0]           pos_north = '0;
  logic                              cfg_valid = 1'b0;
  logic [cls_pkg::CFG_IDX_W-1:0]     cfg_index = cls_pkg::REG_ACCEL_THRESHOLD;
  logic [cls_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                              out_ready = 1'b0;

  logic                              in_ready;
  logic                              cfg_ready;
  logic                              out_valid;
  logic [cls_pkg::PHASE_W-1:0]       phase;
  logic [cls_pkg::THROTTLE_W-1:0]    throttle_cmd;
  logic                              motor_start;
  logic signed [POS_W-1:0]           climb_east;
  logic signed [POS_W-1:0]           climb_north;
  logic                              point_new;
  logic                              zero_distance;
  logic signed [POS_W-1:0]           takeoff_east;
  logic signed [POS_W-1:0]           takeoff_north;

  // Shadow of the sequencer: registers, arming, tick counter, takeoff point
  cls_pkg::cls_cfg_t                settings   = cls_pkg::CFG_RESET;
  logic                             armed      = 1'b0;
  logic [cls_pkg::TICK_W-1:0]       tick_count = '0;
  logic signed [POS_W-1:0]          takeoff_e  = '0;
  logic signed [POS_W-1:0]          takeoff_n  = '0;

  launch_status_t awaited_status[$];
  int             errors     = 0;
  int             beats_sent = 0;
  int             stall      = 0;
  bit             calm       = 1'b0;

  catapult_launch_sequencer_unit #(
    .POS_WIDTH    (POS_W),
    .DETECT_COUNT (DETECT_TICKS)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .accel_fwd_i     (accel),
    .pos_east_i      (pos_east),
    .pos_north_i     (pos_north),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .phase_o         (phase),
    .throttle_cmd_o  (throttle_cmd),
    .motor_start_o   (motor_start),
    .climb_east_o    (climb_east),
    .climb_north_o   (climb_north),
    .point_new_o     (point_new),
    .zero_distance_o (zero_distance),
    .takeoff_east_o  (takeoff_east),
    .takeoff_north_o (takeoff_north)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [cls_pkg::PHASE_W-1:0] launch_phase(
    input logic [cls_pkg::TICK_W-1:0] count
  );
    if (count <= settings.motor_delay_ticks) return cls_pkg::PH_HOLD;
    if (count < settings.heading_delay_ticks) return cls_pkg::PH_POWER;
    if (count == cls_pkg::LOCKED_TICKS) return cls_pkg::PH_CLIMB;
    return cls_pkg::PH_CAPTURE;
  endfunction

  // Bit-by-bit root: keep each bit whose square still fits
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Scale one normalized axis to the climb distance, round, clamp to the
  // position range
  function automatic logic [POS_W-1:0] climb_offset(input logic signed [POS_W-1:0] base,
                                                    input bit neg,
                                                    input logic [63:0] mag,
                                                    input logic [63:0] len);
    logic [63:0] num;
    logic [63:0] off;
    longint      sum;
    num = mag * (64'(settings.climb_distance) << cls_pkg::FRAC_SHIFT);
    off = (num + len / 2) / len;
    sum = neg ? longint'(base) - longint'(off) : longint'(base) + longint'(off);
    if (sum > longint'(POS_MAX)) sum = longint'(POS_MAX);
    if (sum < longint'(POS_MIN)) sum = longint'(POS_MIN);
    return sum[POS_W-1:0];
  endfunction

  // Advance the shadow state by one accepted beat and return its status
  function automatic launch_status_t next_launch_status(
    input logic [cls_pkg::OP_W-1:0]          op_v,
    input logic signed [cls_pkg::ACC_W-1:0]  acc_v,
    input logic signed [POS_W-1:0]           east_v,
    input logic signed [POS_W-1:0]           north_v
  );
    launch_status_t st;
    longint         dx;
    longint         dy;
    logic [63:0]    ax;
    logic [63:0]    ay;
    logic [63:0]    span;
    logic [63:0]    len;
    st = '0;
    case (op_v)
      cls_pkg::OP_TICK: begin
        if (armed) begin
          if (tick_count < settings.heading_delay_ticks) tick_count++;
          // early counts: a weak sample restarts detection
          if (tick_count < DETECT_TICKS) begin
            if (longint'(acc_v) < longint'(settings.accel_threshold)) tick_count = '0;
          end else if (tick_count >= settings.motor_delay_ticks) begin
            st.motor_start = 1'b1;
          end
        end else begin
          tick_count = '0;
        end
        st.phase    = launch_phase(tick_count);
        st.throttle = st.motor_start ? settings.full_throttle : '0;
      end
      cls_pkg::OP_NAV: begin
        armed    = 1'b1;
        st.phase = launch_phase(tick_count);
        case (st.phase)
          cls_pkg::PH_HOLD: begin
            takeoff_e = east_v;
            takeoff_n = north_v;
          end
          cls_pkg::PH_POWER: st.throttle = settings.full_throttle;
          cls_pkg::PH_CAPTURE: begin
            st.throttle  = settings.full_throttle;
            st.point_new = 1'b1;
            tick_count   = cls_pkg::LOCKED_TICKS;
            dx   = longint'(east_v) - longint'(takeoff_e);
            dy   = longint'(north_v) - longint'(takeoff_n);
            ax   = (dx < 0) ? -dx : dx;
            ay   = (dy < 0) ? -dy : dy;
            span = ax | ay;
            if (span == 0) begin
              st.zero_distance = 1'b1;
              st.climb_east    = takeoff_e;
              st.climb_north   = takeoff_n;
            end else begin
              // bring the larger magnitude into [2^30, 2^31)
              while (span >= 64'h8000_0000) begin
                ax >>= 1;
                ay >>= 1;
                span >>= 1;
              end
              while (span < 64'h4000_0000) begin
                ax <<= 1;
                ay <<= 1;
                span <<= 1;
              end
              len            = int_sqrt(ax * ax + ay * ay);
              st.climb_east  = climb_offset(takeoff_e, dx < 0, ax, len);
              st.climb_north = climb_offset(takeoff_n, dy < 0, ay, len);
            end
          end
          default: ;  // climb: throttle belongs to the climb loop
        endcase
      end
      default: begin
        if (op_v == cls_pkg::OP_ARM) begin
          armed      = 1'b1;
          tick_count = '0;
        end
        st.phase = launch_phase(tick_count);
        if (st.phase == cls_pkg::PH_POWER || st.phase == cls_pkg::PH_CAPTURE)
          st.throttle = settings.full_throttle;
      end
    endcase
    st.takeoff_east  = takeoff_e;
    st.takeoff_north = takeoff_n;
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      if (errors < REPORT_LIMIT)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    launch_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_status.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: result beat expected none, got phase %0d", $time, phase);
        errors++;
      end else begin
        want = awaited_status.pop_front();
        check_field("phase", want.phase, phase);
        check_field("throttle_cmd", want.throttle, throttle_cmd);
        check_field("motor_start", want.motor_start, motor_start);
        check_field("climb_east", want.climb_east, climb_east);
        check_field("climb_north", want.climb_north, climb_north);
        check_field("point_new", want.point_new, point_new);
        check_field("zero_distance", want.zero_distance, zero_distance);
        check_field("takeoff_east", want.takeoff_east, takeoff_east);
        check_field("takeoff_north", want.takeoff_north, takeoff_north);
      end
    end
  end

  // Stall the result side at random, except through the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Drop the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Send one beat. Valid may still be high from the previous beat at this
  // step; either drop it for a gap or load the next payload straight away.
  task automatic send_beat(input logic [cls_pkg::OP_W-1:0] op_v,
                           input logic signed [cls_pkg::ACC_W-1:0] acc_v,
                           input logic signed [POS_W-1:0] east_v,
                           input logic signed [POS_W-1:0] north_v);
    if (take_break()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    in_valid  <= 1'b1;
    op        <= op_v;
    accel     <= acc_v;
    pos_east  <= east_v;
    pos_north <= north_v;
    do @(posedge clk); while (!in_ready);
    awaited_status.push_back(next_launch_status(op_v, acc_v, east_v, north_v));
    beats_sent++;
  endtask

  // Drop valid and hold until every expected result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // Write the registers selected by mask; only call with the block idle
  task automatic load_settings(input cls_pkg::cls_cfg_t s, input logic [4:0] mask);
    logic [cls_pkg::CFG_DATA_W-1:0] data;
    for (int i = 0; i < 5; i++) begin
      if (mask[i]) begin
        case (cls_pkg::CFG_IDX_W'(i))
          cls_pkg::REG_ACCEL_THRESHOLD: data = s.accel_threshold;
          cls_pkg::REG_MOTOR_DELAY:     data = cls_pkg::CFG_DATA_W'(s.motor_delay_ticks);
          cls_pkg::REG_HEADING_DELAY:   data = cls_pkg::CFG_DATA_W'(s.heading_delay_ticks);
          cls_pkg::REG_FULL_THROTTLE:   data = cls_pkg::CFG_DATA_W'(s.full_throttle);
          default:                      data = cls_pkg::CFG_DATA_W'(s.climb_distance);
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= cls_pkg::CFG_IDX_W'(i);
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (cls_pkg::CFG_IDX_W'(i))
          cls_pkg::REG_ACCEL_THRESHOLD: settings.accel_threshold = s.accel_threshold;
          cls_pkg::REG_MOTOR_DELAY:     settings.motor_delay_ticks = s.motor_delay_ticks;
          cls_pkg::REG_HEADING_DELAY:   settings.heading_delay_ticks = s.heading_delay_ticks;
          cls_pkg::REG_FULL_THROTTLE:   settings.full_throttle = s.full_throttle;
          default:                      settings.climb_distance = s.climb_distance;
        endcase
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly samples that pass detection, now and then anything at all
  function automatic logic signed [cls_pkg::ACC_W-1:0] launch_accel();
    if ($urandom_range(99) < 85)
      return cls_pkg::ACC_W'(settings.accel_threshold
                             + $urandom_range(0, 524287 - settings.accel_threshold));
    return cls_pkg::ACC_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Unused op, unarmed tick, detection restart, motor start, counter
  // saturation at the heading delay, and a long-range capture
  task automatic test_detection_and_motor_start();
    cls_pkg::cls_cfg_t s;
    s = '{accel_threshold: 19'd1000, motor_delay_ticks: 16'd5, heading_delay_ticks: 16'd7,
          full_throttle: 14'd9600, climb_distance: 16'hffff};
    load_settings(s, 5'h1f);
    send_beat(OP_SPARE, ACC_MIN, POS_MIN, POS_MIN);
    send_beat(cls_pkg::OP_TICK, ACC_MAX, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, POS_MAX, POS_MIN);
    send_beat(cls_pkg::OP_TICK, ACC_MIN, '0, '0);
    send_beat(cls_pkg::OP_ARM, '0, '1, '1);
    repeat (8) send_beat(cls_pkg::OP_TICK, ACC_MAX, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, POS_MIN, POS_MAX);
  endtask

  // Zero-distance capture, climb phase, and clamping of the climb point
  task automatic test_capture_corners();
    cls_pkg::cls_cfg_t s;
    wait_idle();
    s = '{accel_threshold: 19'd0, motor_delay_ticks: 16'd0, heading_delay_ticks: 16'd1,
          full_throttle: 14'd0, climb_distance: 16'hffff};
    load_settings(s, 5'h1f);
    send_beat(cls_pkg::OP_ARM, '0, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, 32'sh1234_5600, -32'sh0abc_de00);
    send_beat(cls_pkg::OP_TICK, '0, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, 32'sh1234_5600, -32'sh0abc_de00);
    send_beat(cls_pkg::OP_NAV, '0, '0, '0);
    send_beat(cls_pkg::OP_TICK, ACC_MIN, '0, '0);
    send_beat(cls_pkg::OP_ARM, '0, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, 32'sh7fff_ff00, 32'sh8000_0100);
    send_beat(cls_pkg::OP_TICK, '0, '0, '0);
    send_beat(cls_pkg::OP_NAV, '0, POS_MAX, POS_MIN);
  endtask

  // Arm, store takeoff, tick toward capture for at most 24 ticks, then a nav step and a little climb
  task automatic fly_launch();
    logic signed [POS_W-1:0] east;
    logic signed [POS_W-1:0] north;
    logic signed [POS_W-1:0] de;
    logic signed [POS_W-1:0] dn;
    int                      ticks;
    east  = $urandom;
    north = $urandom;
    send_beat(cls_pkg::OP_ARM, cls_pkg::ACC_W'($urandom), $urandom, $urandom);
    send_beat(cls_pkg::OP_NAV, cls_pkg::ACC_W'($urandom), east, north);
    ticks = 0;
    while (launch_phase(tick_count) != cls_pkg::PH_CAPTURE && ticks < 24) begin
      send_beat(cls_pkg::OP_TICK, launch_accel(), $urandom, $urandom);
      ticks++;
      if ($urandom_range(9) == 0)
        send_beat(cls_pkg::OP_NAV, cls_pkg::ACC_W'($urandom),
                  east + ($urandom_range(0, 511) - 256), north);
    end
    // distance of any scale, sometimes none
    de = $signed($urandom) >>> $urandom_range(0, 31);
    dn = $signed($urandom) >>> $urandom_range(0, 31);
    if ($urandom_range(9) == 0) begin
      de = '0;
      dn = '0;
    end
    send_beat(cls_pkg::OP_NAV, cls_pkg::ACC_W'($urandom), east + de, north + dn);
    repeat ($urandom_range(0, 3))
      send_beat($urandom_range(0, 1) ? cls_pkg::OP_NAV : cls_pkg::OP_TICK, launch_accel(),
                $urandom, $urandom);
  endtask

  // Rounds of random settings, each mostly well-formed launches plus noise
  task automatic test_random_launches();
    cls_pkg::cls_cfg_t s;
    int                first;
    int                round_first;
    int                round;
    first = beats_sent;
    round = 0;
    while (beats_sent - first < RANDOM_BEATS) begin
      wait_idle();
      case (round)
        0: s = '{accel_threshold: 19'h7ffff, motor_delay_ticks: 16'd0,
                 heading_delay_ticks: 16'd3, full_throttle: 14'd9600, climb_distance: 16'd0};
        1: s = '{accel_threshold: 19'd0, motor_delay_ticks: 16'd65534,
                 heading_delay_ticks: 16'd65534, full_throttle: 14'd0, climb_distance: 16'hffff};
        default: begin
          case ($urandom_range(0, 3))
            0:       s.accel_threshold = '0;
            1:       s.accel_threshold = 19'h7ffff;
            default: s.accel_threshold = $urandom_range(0, 40000);
          endcase
          s.motor_delay_ticks = $urandom_range(0, 10);
          if ($urandom_range(0, 4) == 0)
            s.heading_delay_ticks = $urandom_range(0, 12);
          else
            s.heading_delay_ticks = s.motor_delay_ticks + $urandom_range(1, 8);
          s.full_throttle  = $urandom_range(0, 9600);
          s.climb_distance = ($urandom_range(0, 3) == 0) ? 16'hffff : $urandom_range(0, 2000);
        end
      endcase
      load_settings(s, (round < 2) ? 5'h1f : 5'($urandom_range(1, 31)));
      // one stretch with no idling on either side
      calm = (round == 4);
      round_first = beats_sent;
      while (beats_sent - round_first < ROUND_BEATS) begin
        if ($urandom_range(99) < 80)
          fly_launch();
        else
          send_beat(cls_pkg::OP_W'($urandom_range(0, 3)), cls_pkg::ACC_W'($urandom),
                    $urandom, $urandom);
      end
      round++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_detection_and_motor_start();
    test_capture_corners();
    test_random_launches();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cls_pkg.sv
hdl/cls_cfg_regs.sv
hdl/cls_climb.sv
hdl/catapult_launch_sequencer_unit.sv
hdl/cls_checker.sv
test/catapult_launch_sequencer_unit_tb.sv
